FILE: rtl/pmst_pkg.sv
`timescale 1ns / 1ps

package pmst_pkg;

  localparam int VERTEX_BITS = 5;
  localparam int WEIGHT_IN_BITS = 16;
  localparam int TOTAL_BITS = 20;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
  localparam logic [VERTEX_BITS-1:0] VC_RESET = 5'd16;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_RUN = 1'b1;
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic [VERTEX_BITS-1:0]    from_vertex;
    logic [VERTEX_BITS-1:0]    to_vertex;
    logic [WEIGHT_IN_BITS-1:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic                   kind;
    logic [VERTEX_BITS-1:0] parent_vertex;
    logic [VERTEX_BITS-1:0] child_vertex;
    logic [TOTAL_BITS-1:0]  total_weight;
    logic                   last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RELAX,
    S_RELAX_END,
    S_DECIDE,
    S_EMIT,
    S_EMIT_END,
    S_TOTAL
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic edge_write;
    logic run_start;
    logic relax_issue;
    logic pass_end;
    logic emit_issue;
    logic total_emit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_last;
    logic found;
  } status_t;

endpackage

FILE: rtl/pmst_ctrl.sv
`timescale 1ns / 1ps

module pmst_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             mode,
  input  pmst_pkg::status_t status,
  output pmst_pkg::cmd_t   cmd,
  output logic             busy
);

  pmst_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmst_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    case (state)
      pmst_pkg::S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) state_next = pmst_pkg::S_IDLE;
      end
      pmst_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (mode == pmst_pkg::MODE_RUN) begin
            cmd.run_start = 1'b1;
            state_next = pmst_pkg::S_RELAX;
          end else begin
            cmd.edge_write = 1'b1;
          end
        end
      end
      pmst_pkg::S_RELAX: begin
        cmd.relax_issue = 1'b1;
        if (status.scan_last) state_next = pmst_pkg::S_RELAX_END;
      end
      pmst_pkg::S_RELAX_END: begin
        state_next = pmst_pkg::S_DECIDE;
      end
      pmst_pkg::S_DECIDE: begin
        cmd.pass_end = 1'b1;
        state_next = status.found ? pmst_pkg::S_RELAX : pmst_pkg::S_EMIT;
      end
      pmst_pkg::S_EMIT: begin
        cmd.emit_issue = 1'b1;
        if (status.scan_last) state_next = pmst_pkg::S_EMIT_END;
      end
      pmst_pkg::S_EMIT_END: begin
        state_next = pmst_pkg::S_TOTAL;
      end
      pmst_pkg::S_TOTAL: begin
        cmd.total_emit = 1'b1;
        state_next = pmst_pkg::S_IDLE;
      end
      default: begin
        state_next = pmst_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/pmst_datapath.sv
`timescale 1ns / 1ps

module pmst_datapath #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  pmst_pkg::cmd_t      cmd,
  output pmst_pkg::status_t   status,
  input  pmst_pkg::in_item_t  request,
  input  logic                cfg_we,
  input  logic [pmst_pkg::VERTEX_BITS-1:0] cfg_data,
  output logic                strobe,
  output pmst_pkg::out_item_t result
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int AW = 2 * VW;
  localparam int DEPTH = 1 << AW;
  localparam int SW = ((WEIGHT_BITS > pmst_pkg::TOTAL_BITS) ? WEIGHT_BITS
                                                            : pmst_pkg::TOTAL_BITS) + 1;

  logic [pmst_pkg::VERTEX_BITS-1:0] vertex_count;
  logic [pmst_pkg::VERTEX_BITS-1:0] n_eff;

  logic [WEIGHT_BITS-1:0] edge_mem [DEPTH];
  logic [WEIGHT_BITS-1:0] key_mem [MAX_VERTICES];
  logic [VW-1:0]          par_mem [MAX_VERTICES];

  logic [AW-1:0] clr_addr;
  logic [VW-1:0] idx;
  logic [VW-1:0] pick;
  logic [MAX_VERTICES-1:0] in_tree;
  logic [MAX_VERTICES-1:0] key_valid;

  logic                   relax_b;
  logic                   emit_b;
  logic [VW-1:0]          vb;
  logic [WEIGHT_BITS-1:0] edge_rd;
  logic [WEIGHT_BITS-1:0] key_rd;
  logic [VW-1:0]          par_rd;

  logic                   best_found;
  logic [WEIGHT_BITS-1:0] best_key;
  logic [VW-1:0]          best_v;
  logic [pmst_pkg::TOTAL_BITS-1:0] total;

  logic [VW-1:0]          a_idx, b_idx;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic                   ok_write;
  logic [WEIGHT_BITS-1:0] w_in;
  logic                   intree_b, valid_b, upd, new_fin, better;
  logic [WEIGHT_BITS-1:0] new_key;
  logic [SW-1:0]          sum;

  // effective vertex count
  always_comb begin
    if (vertex_count == '0) begin
      n_eff = 5'd1;
    end else if (32'(vertex_count) > MAX_VERTICES) begin
      n_eff = pmst_pkg::VERTEX_BITS'(MAX_VERTICES);
    end else begin
      n_eff = vertex_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= pmst_pkg::VC_RESET;
    end else if (cfg_we) begin
      vertex_count <= cfg_data;
    end
  end

  // edge write, upper triangle only
  always_comb begin
    a_idx = VW'(request.from_vertex - 5'd1);
    b_idx = VW'(request.to_vertex - 5'd1);
    ok_write = (request.from_vertex != '0) && (request.to_vertex != '0) &&
               (request.from_vertex <= n_eff) && (request.to_vertex <= n_eff);
    w_in = WEIGHT_BITS'(request.edge_weight);
    wr_addr = (a_idx < b_idx) ? {a_idx, b_idx} : {b_idx, a_idx};
    rd_addr = (pick < idx) ? {pick, idx} : {idx, pick};
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      edge_mem[clr_addr] <= '0;
    end else if (cmd.edge_write && ok_write) begin
      edge_mem[wr_addr] <= w_in;
    end
    edge_rd <= edge_mem[rd_addr];
  end

  // relax step on the registered reads
  always_comb begin
    intree_b = in_tree[vb];
    valid_b = key_valid[vb];
    upd = relax_b && (edge_rd != '0) && !intree_b && (!valid_b || (edge_rd < key_rd));
    new_fin = upd || valid_b;
    new_key = upd ? edge_rd : key_rd;
    better = relax_b && !intree_b && new_fin && (!best_found || (new_key < best_key));
    sum = SW'(total) + SW'(best_key);
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      key_mem[vb] <= edge_rd;
      par_mem[vb] <= pick;
    end
    key_rd <= key_mem[idx];
    par_rd <= par_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      idx <= '0;
      vb <= '0;
      pick <= '0;
      in_tree <= '0;
      key_valid <= '0;
      relax_b <= 1'b0;
      emit_b <= 1'b0;
      best_found <= 1'b0;
      total <= '0;
    end else begin
      relax_b <= cmd.relax_issue;
      emit_b <= cmd.emit_issue;
      vb <= idx;
      if (cmd.clear_step) clr_addr <= clr_addr + 1'b1;
      if (cmd.relax_issue || cmd.emit_issue) idx <= idx + 1'b1;
      if (upd) key_valid[vb] <= 1'b1;
      if (better) begin
        best_found <= 1'b1;
        best_key <= new_key;
        best_v <= vb;
      end
      if (cmd.run_start) begin
        idx <= '0;
        pick <= '0;
        in_tree <= MAX_VERTICES'(1);
        key_valid <= '0;
        best_found <= 1'b0;
        total <= '0;
      end
      if (cmd.pass_end) begin
        idx <= '0;
        best_found <= 1'b0;
        if (best_found) begin
          pick <= best_v;
          in_tree[best_v] <= 1'b1;
          if (sum > SW'(pmst_pkg::TOTAL_MAX)) begin
            total <= pmst_pkg::TOTAL_MAX;
          end else begin
            total <= pmst_pkg::TOTAL_BITS'(sum);
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.total_emit || (emit_b && key_valid[vb]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.total_emit) begin
      result.kind <= pmst_pkg::KIND_TOTAL;
      result.parent_vertex <= '0;
      result.child_vertex <= '0;
      result.total_weight <= total;
      result.last <= 1'b1;
    end else begin
      result.kind <= pmst_pkg::KIND_EDGE;
      result.parent_vertex <= pmst_pkg::VERTEX_BITS'(par_rd) + 5'd1;
      result.child_vertex <= pmst_pkg::VERTEX_BITS'(vb) + 5'd1;
      result.total_weight <= '0;
      result.last <= 1'b0;
    end
  end

  assign status.clear_last = (clr_addr == '1);
  assign status.scan_last = (32'(idx) == 32'(n_eff - 5'd1));
  assign status.found = best_found;

endmodule

FILE: rtl/prim_minimum_spanning_tree_core.sv
`timescale 1ns / 1ps

// channel   signals                  accepted when
// request   start, busy, request     rising edge with start high and busy low
// result    strobe, result           every cycle strobe is high, no stall
// config    cfg_we, cfg_data         rising edge with cfg_we high
//
// an edge write item leaves busy low; back to back writes are accepted
// a run item holds busy through a relax pass for each vertex joined, each pass reading
// one matrix entry per cycle; the total item follows in the first idle cycle
// after reset a clearing pass sweeps all 2^(2*clog2(MAX_VERTICES)) edge memory entries
// (256 at default), with busy high
// results come one per cycle at most from a register and cannot be held off

module prim_minimum_spanning_tree_core #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  pmst_pkg::in_item_t  request,
  output logic                strobe,
  output pmst_pkg::out_item_t result,
  input  logic                cfg_we,
  input  logic [pmst_pkg::VERTEX_BITS-1:0] cfg_data
);

  pmst_pkg::cmd_t    cmd;
  pmst_pkg::status_t status;

  pmst_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (request.mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  pmst_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .request  (request),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .strobe   (strobe),
    .result   (result)
  );

endmodule

FILE: bench/tb_prim_minimum_spanning_tree_core.sv
`timescale 1ns / 1ps

module tb_prim_minimum_spanning_tree_core;

  localparam int NV = 16;
  localparam logic [16:0] KEY_INF = 17'h10000;
  localparam int PHASE_ITEMS = 40;
  localparam int NUM_PHASES = 8;

  typedef enum logic [1:0] {STEP_CFG, STEP_ITEM, STEP_RUN_TOTAL} step_kind_t;

  typedef struct packed {
    step_kind_t                       what;
    pmst_pkg::in_item_t               item;
    logic [pmst_pkg::VERTEX_BITS-1:0] count;
    logic [pmst_pkg::TOTAL_BITS-1:0]  total;
  } step_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  pmst_pkg::in_item_t request;
  logic strobe;
  pmst_pkg::out_item_t result;
  logic cfg_we;
  logic [pmst_pkg::VERTEX_BITS-1:0] cfg_data;

  logic [pmst_pkg::WEIGHT_IN_BITS-1:0] adj [NV][NV];
  logic [pmst_pkg::VERTEX_BITS-1:0] vc_shadow;
  pmst_pkg::out_item_t mst_items_q[$];
  step_t plan[$];
  int mismatches = 0;

  prim_minimum_spanning_tree_core DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .strobe(strobe),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [19:0] got,
                             input logic [19:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic int active_vertices();
    if (vc_shadow == '0) return 1;
    if (int'(vc_shadow) > NV) return NV;
    return int'(vc_shadow);
  endfunction

  function automatic bit write_lands(input pmst_pkg::in_item_t it);
    int n;
    n = active_vertices();
    return it.from_vertex != '0 && it.to_vertex != '0 &&
           int'(it.from_vertex) <= n && int'(it.to_vertex) <= n;
  endfunction

  function automatic void apply_write(input pmst_pkg::in_item_t it);
    if (write_lands(it)) begin
      adj[it.from_vertex - 1][it.to_vertex - 1] = it.edge_weight;
      adj[it.to_vertex - 1][it.from_vertex - 1] = it.edge_weight;
    end
  endfunction

  function automatic void queue_tree_items();
    logic [16:0] key [NV];
    logic [pmst_pkg::VERTEX_BITS-1:0] parent [NV];
    bit joined [NV];
    logic [20:0] sum;
    logic [16:0] best;
    int n;
    int pick;
    pmst_pkg::out_item_t item;
    n = active_vertices();
    for (int v = 0; v < NV; v++) begin
      key[v] = KEY_INF;
      parent[v] = '0;
      joined[v] = 1'b0;
    end
    key[0] = '0;
    sum = '0;
    for (int round = 0; round < n; round++) begin
      pick = n;
      best = KEY_INF;
      for (int v = 0; v < n; v++) begin
        if (!joined[v] && key[v] < best) begin
          best = key[v];
          pick = v;
        end
      end
      if (pick == n) break;
      joined[pick] = 1'b1;
      sum = sum + best;
      if (sum > pmst_pkg::TOTAL_MAX) sum = {1'b0, pmst_pkg::TOTAL_MAX};
      for (int v = 0; v < n; v++) begin
        if (adj[pick][v] != '0 && !joined[v] && {1'b0, adj[pick][v]} < key[v]) begin
          key[v] = {1'b0, adj[pick][v]};
          parent[v] = pmst_pkg::VERTEX_BITS'(pick + 1);
        end
      end
    end
    for (int v = 0; v < n; v++) begin
      if (parent[v] != '0) begin
        item = '0;
        item.kind = pmst_pkg::KIND_EDGE;
        item.parent_vertex = parent[v];
        item.child_vertex = pmst_pkg::VERTEX_BITS'(v + 1);
        mst_items_q.push_back(item);
      end
    end
    item = '0;
    item.kind = pmst_pkg::KIND_TOTAL;
    item.total_weight = sum[pmst_pkg::TOTAL_BITS-1:0];
    item.last = 1'b1;
    mst_items_q.push_back(item);
  endfunction

  function automatic pmst_pkg::in_item_t mk_item(input logic mode, input int a, input int b,
                                                 input logic [pmst_pkg::WEIGHT_IN_BITS-1:0] w);
    pmst_pkg::in_item_t it;
    it.mode = mode;
    it.from_vertex = pmst_pkg::VERTEX_BITS'(a);
    it.to_vertex = pmst_pkg::VERTEX_BITS'(b);
    it.edge_weight = w;
    return it;
  endfunction

  function automatic void plan_write(input int a, input int b,
                                     input logic [pmst_pkg::WEIGHT_IN_BITS-1:0] w);
    plan.push_back('{STEP_ITEM, mk_item(pmst_pkg::MODE_WRITE, a, b, w), '0, '0});
  endfunction

  function automatic void plan_run();
    plan.push_back('{STEP_ITEM, mk_item(pmst_pkg::MODE_RUN, 0, 0, '0), '0, '0});
  endfunction

  function automatic void plan_run_total(input logic [pmst_pkg::TOTAL_BITS-1:0] t);
    plan.push_back('{STEP_RUN_TOTAL, mk_item(pmst_pkg::MODE_RUN, 31, 31, 16'hFFFF), '0, t});
  endfunction

  function automatic void plan_cfg(input logic [pmst_pkg::VERTEX_BITS-1:0] v);
    plan.push_back('{STEP_CFG, '0, v, '0});
  endfunction

  function automatic logic [pmst_pkg::WEIGHT_IN_BITS-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return pmst_pkg::WEIGHT_IN_BITS'($urandom);
      default: return pmst_pkg::WEIGHT_IN_BITS'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic send_item(input pmst_pkg::in_item_t it, input bit use_typed,
                           input logic [pmst_pkg::TOTAL_BITS-1:0] typed_total);
    pmst_pkg::out_item_t item;
    start <= 1'b1;
    request <= it;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (it.mode == pmst_pkg::MODE_WRITE) begin
      apply_write(it);
    end else if (use_typed) begin
      item = '0;
      item.kind = pmst_pkg::KIND_TOTAL;
      item.total_weight = typed_total;
      item.last = 1'b1;
      mst_items_q.push_back(item);
    end else begin
      queue_tree_items();
    end
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 9)) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (mst_items_q.size() != 0);
    repeat (4) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [pmst_pkg::VERTEX_BITS-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    vc_shadow = v;
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    pmst_pkg::out_item_t want;
    if (rst === 1'b0 && strobe === 1'b1) begin
      if (mst_items_q.size() == 0) begin
        note_mismatch($sformatf("result %h with nothing pending", result));
      end else begin
        want = mst_items_q.pop_front();
        check_field("kind", 20'(result.kind), 20'(want.kind));
        check_field("parent_vertex", 20'(result.parent_vertex), 20'(want.parent_vertex));
        check_field("child_vertex", 20'(result.child_vertex), 20'(want.child_vertex));
        check_field("total_weight", result.total_weight, want.total_weight);
        check_field("last", 20'(result.last), 20'(want.last));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int phase_counts [NUM_PHASES];
    int n;
    int landed;
    int r;
    int waited;
    pmst_pkg::in_item_t it;
    pmst_pkg::out_item_t left;

    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    vc_shadow = pmst_pkg::VC_RESET;
    for (int i = 0; i < NV; i++)
      for (int j = 0; j < NV; j++)
        adj[i][j] = '0;

    // empty matrix, bad endpoints, self loop
    plan_run_total(20'd0);
    plan_write(0, 5, 16'd7);
    plan_write(5, 0, 16'd7);
    plan_write(17, 3, 16'd9);
    plan_write(31, 31, 16'hFFFF);
    plan_run_total(20'd0);
    plan_write(1, 1, 16'hFFFF);
    plan_run_total(20'd0);
    // extremes, ties, overwrite, unreached part
    plan_write(1, 16, 16'hFFFF);
    plan_write(16, 2, 16'd1);
    plan_write(2, 3, 16'h8000);
    plan_write(3, 1, 16'h8000);
    plan_write(4, 5, 16'h5555);
    plan_write(3, 2, 16'hAAAA);
    plan_run();
    plan_write(2, 16, 16'd0);
    plan_write(1, 2, 16'd3);
    plan_write(1, 3, 16'd3);
    plan_write(2, 3, 16'd2);
    plan_run();
    // shrunk and out of range vertex counts
    plan_cfg(5'd3);
    plan_run();
    plan_cfg(5'd0);
    plan_run_total(20'd0);
    plan_cfg(5'd31);
    plan_run();
    plan_cfg(5'd1);
    plan_write(1, 2, 16'd5);
    plan_run_total(20'd0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].what != STEP_CFG && $urandom_range(0, 3) == 0) idle_burst();
      case (plan[i].what)
        STEP_CFG: begin
          settle();
          write_cfg(plan[i].count);
        end
        STEP_ITEM: send_item(plan[i].item, 1'b0, '0);
        default: send_item(plan[i].item, 1'b1, plan[i].total);
      endcase
    end

    phase_counts = '{2, 16, 1, 0, 31, 5, $urandom_range(3, 15), 16};
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_cfg(pmst_pkg::VERTEX_BITS'(phase_counts[p]));
      n = active_vertices();
      landed = 0;
      while (landed < PHASE_ITEMS) begin
        // final phase runs back to back
        if (p != NUM_PHASES - 1) begin
          if ($urandom_range(0, 4) == 0) idle_burst();
          if ($urandom_range(0, 39) == 0) settle();
        end
        r = $urandom_range(0, 99);
        if (r < 8)
          it = mk_item(pmst_pkg::MODE_WRITE, $urandom_range(0, 31), $urandom_range(0, 31),
                       pick_weight());
        else if (r < 80)
          it = mk_item(pmst_pkg::MODE_WRITE, $urandom_range(1, n), $urandom_range(1, n),
                       pick_weight());
        else
          it = mk_item(pmst_pkg::MODE_RUN, $urandom_range(0, 31), $urandom_range(0, 31),
                       pmst_pkg::WEIGHT_IN_BITS'($urandom));
        if (it.mode == pmst_pkg::MODE_RUN || write_lands(it)) landed++;
        send_item(it, 1'b0, '0);
      end
    end

    start <= 1'b0;
    waited = 0;
    while (mst_items_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (400) @(posedge clk);
    while (mst_items_q.size() != 0) begin
      left = mst_items_q.pop_front();
      note_mismatch($sformatf("result %h never arrived", left));
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
